[sv/ssfpw_pkg.sv]
// Shared constants, codes and unit handshake types of the SSF partition weight block.
`default_nettype none
package ssfpw_pkg;
   localparam int MAX_ATOMS_DEF = 64;

   localparam int DIST_W   = 32;
   localparam int WEIGHT_W = 48;
   localparam int PROD_W   = 47;   // Q1.46 cell products and switch values
   localparam int FRAC_W   = 31;   // |mu/a| in Q0.31
   localparam int MUL_W    = 48;   // multiplier operand width
   localparam int MULP_W   = 96;
   localparam int DIV_W    = 56;   // divisor and remainder width
   localparam int DIVN_W   = 96;   // dividend bits shifted in
   localparam int DIVQ_W   = 48;
   localparam int STEP_W   = 7;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [PROD_W-1:0] Q46_ONE = PROD_W'(1) << 46;
   localparam logic [PROD_W-1:0] TOL_Q46 = PROD_W'(7036);

   localparam logic [1:0] OP_LOAD_PAIR  = 2'd0;
   localparam logic [1:0] OP_LOAD_POINT = 2'd1;
   localparam logic [1:0] OP_COMPUTE    = 2'd2;

   localparam logic [1:0] ST_SCALED  = 2'd0;
   localparam logic [1:0] ST_SKIPPED = 2'd1;
   localparam logic [1:0] ST_ZEROED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ATOM_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SSF_FACTOR = 1'b1;

   localparam logic [6:0]  ATOM_COUNT_RST = 7'd1;
   localparam logic [15:0] SSF_FACTOR_RST = 16'd41943;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  rem;
      logic [DIVN_W-1:0] num;
      logic [DIV_W-1:0]  den;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic busy;
   } unit_sts_type;
endpackage
`default_nettype wire

[sv/ssfpw_req_if.sv]
// Request channel interface: valid/ready handshake with the item fields.
`default_nettype none
interface ssfpw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [5:0]  atom_row;
   logic [5:0]  atom_col;
   logic [31:0] distance_value;
   logic [5:0]  parent_atom;
   logic [31:0] nearest_distance;
   logic [47:0] weight_in;

   modport source (output valid, opcode, atom_row, atom_col, distance_value,
                   parent_atom, nearest_distance, weight_in, input ready);
   modport sink (input valid, opcode, atom_row, atom_col, distance_value,
                 parent_atom, nearest_distance, weight_in, output ready);
endinterface
`default_nettype wire

[sv/ssfpw_rsp_if.sv]
// Response channel interface: valid/ready handshake with the result fields.
`default_nettype none
interface ssfpw_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] weight_out;
   logic [1:0]  status;

   modport source (output valid, weight_out, status, input ready);
   modport sink (input valid, weight_out, status, output ready);
endinterface
`default_nettype wire

[sv/ssfpw_mul_unit.sv]
// Shared 48x48 multiplier, radix-256 shift-add, one byte of b per cycle.
`default_nettype none
module ssfpw_mul_unit
   import ssfpw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mul_req_type       req,
   output      unit_sts_type      sts,
   output      logic [MULP_W-1:0] product
);
   localparam int STEPS = MUL_W / 8;

   logic [MUL_W-1:0]  a_ff;
   logic [MUL_W-1:0]  b_ff;
   logic [MULP_W-1:0] acc_ff;
   logic [2:0]        cnt_ff;
   logic              done_ff;
   logic [MUL_W+7:0]  part;

   assign part = a_ff * (MUL_W+8)'(b_ff[MUL_W-1 -: 8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         a_ff    <= req.a;
         b_ff    <= req.b;
         acc_ff  <= '0;
         cnt_ff  <= 3'(STEPS);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         acc_ff  <= {acc_ff[MULP_W-9:0], 8'b0} + MULP_W'(part);
         b_ff    <= {b_ff[MUL_W-9:0], 8'b0};
         cnt_ff  <= cnt_ff - 3'd1;
         done_ff <= (cnt_ff == 3'd1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign sts.done = done_ff;
   assign sts.busy = (cnt_ff != '0);
   assign product  = acc_ff;
endmodule
`default_nettype wire

[sv/ssfpw_div_unit.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module ssfpw_div_unit
   import ssfpw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_req_type       req,
   output      unit_sts_type      sts,
   output      logic [DIVQ_W-1:0] quotient
);
   logic [DIV_W-1:0]  rem_ff;
   logic [DIVN_W-1:0] num_ff;
   logic [DIV_W-1:0]  den_ff;
   logic [DIVQ_W-1:0] q_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;
   logic              ge;

   assign shifted = {rem_ff, num_ff[DIVN_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         rem_ff  <= req.rem;
         num_ff  <= req.num;
         den_ff  <= req.den;
         q_ff    <= '0;
         cnt_ff  <= req.steps;
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         num_ff  <= {num_ff[DIVN_W-2:0], 1'b0};
         q_ff    <= {q_ff[DIVQ_W-2:0], ge};
         cnt_ff  <= cnt_ff - STEP_W'(1);
         done_ff <= (cnt_ff == STEP_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign sts.done = done_ff;
   assign sts.busy = (cnt_ff != '0);
   assign quotient = q_ff;
endmodule
`default_nettype wire

[sv/ssf_partition_weight_core.sv]
// SSF partition weight core: distance stores, sequencer and shared arithmetic units.
//
// Usage: items arrive on req_ch (valid/ready). Opcode 0 writes one atom-pair
// distance, opcode 1 one point-to-atom distance; neither gives a result.
// Opcode 2 computes one quadrature point and gives exactly one
// item on rsp_ch: the rescaled weight with status scaled, skipped or zeroed.
// Stores hold garbage after reset and must be loaded before use.
// csr_* writes atom_count and ssf_factor; the user must do so only while the
// core is idle, as the core itself does not enforce it. A compute item skipped
// by the cutoff finishes early; otherwise each atom pair needing the polynomial
// runs its products on one shared 48x48 radix-256 multiplier and mu/a on a
// one-bit-per-cycle divider, a saturated pair needs fewer steps, and a final
// weight*P/sum closes the item. req_ch.ready is high only while idle;
// loads are still taken while a result waits in the output register.
// A stalled rsp_ch holds the result; a second compute result waits until
// the first is taken. Reset clears control state and the registers to
// atom_count 1 and ssf_factor 0.64.
`default_nettype none
module ssf_partition_weight_core
   import ssfpw_pkg::*;
#(
   parameter int MAX_ATOMS = MAX_ATOMS_DEF
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   ssfpw_req_if.sink                 req_ch,
   ssfpw_rsp_if.source               rsp_ch,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);
   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int SUM_W = DIV_W;

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_CUT, S_CUTD, S_CELL, S_CELLR, S_JCHK, S_JRD, S_DEN,
      S_T1, S_T2, S_T3, S_T5, S_T7, S_PSM, S_PSD, S_CEND, S_CNEXT, S_FIN,
      S_FDIV, S_FQ, S_OUT, S_MW, S_DW
   } state_type;

   state_type         state_ff, ret_ff;
   logic [6:0]        atom_count_ff;
   logic [15:0]       ssf_ff;
   logic [5:0]        parent_ff;
   logic [31:0]       nearest_ff;
   logic [47:0]       w_ff;
   logic [CW-1:0]     cell_ff, j_ff;
   logic              first_ff;
   logic [31:0]       ri_ff;
   logic [PROD_W-1:0] ps_ff, pp_ff, s_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              pos_ff;
   logic [47:0]       mag_ff;
   logic [FRAC_W-1:0] t_ff, t2_ff, t3_ff, t5_ff;
   logic [47:0]       res_w_ff;
   logic [1:0]        res_st_ff;
   logic              rsp_valid_ff;
   logic [47:0]       rsp_w_ff;
   logic [1:0]        rsp_st_ff;

   logic [31:0]       point_mem [MAX_ATOMS];
   logic [31:0]       pair_mem [2**(2*AW)];
   logic [31:0]       pt_rd_ff, pr_rd_ff;
   logic [AW-1:0]     pt_addr;

   mul_req_type       mul_req;
   div_req_type       div_req;
   unit_sts_type      mul_sts, div_sts;
   logic [MULP_W-1:0] mul_p;
   logic [DIVQ_W-1:0] div_q;

   logic [CW-1:0]     n_atoms;
   logic [AW-1:0]     par_idx;
   logic              accept;
   logic              ri_ge;
   logic [31:0]       dabs;
   logic [16:0]       one_minus_a;
   logic [FRAC_W-1:0] hi31;
   logic signed [39:0] poly;
   logic [PROD_W-1:0] g46;
   logic [47:0]       s_plus;
   logic [PROD_W-1:0] s_minus;

   assign n_atoms = (32'(atom_count_ff) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(atom_count_ff);
   assign par_idx = AW'(parent_ff);
   assign accept  = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign one_minus_a = 17'h10000 - {1'b0, ssf_ff};
   assign hi31 = mul_p[2*FRAC_W-1:FRAC_W];
   assign ri_ge = (ri_ff >= pt_rd_ff);
   assign dabs = ri_ge ? (ri_ff - pt_rd_ff) : (pt_rd_ff - ri_ff);

   // switching polynomial, t7 arrives from the multiplier
   always_comb begin
      poly = 40'sd35 * ($signed(40'(t_ff)) - $signed(40'(t3_ff)))
           + 40'sd21 * $signed(40'(t5_ff)) - 40'sd5 * $signed(40'(hi31));
      if (poly < 0)
         g46 = '0;
      else if (poly > $signed(40'(1) <<< 35))
         g46 = Q46_ONE;
      else
         g46 = {poly[35:0], 11'b0};
      s_plus  = {1'b0, Q46_ONE} + {1'b0, g46};
      s_minus = Q46_ONE - g46;
   end

   always_comb begin
      case (state_ff)
         S_CHK:   pt_addr = par_idx;
         S_CELL:  pt_addr = cell_ff[AW-1:0];
         default: pt_addr = j_ff[AW-1:0];
      endcase
   end

   always_comb begin
      mul_req = '0;
      div_req = '0;
      case (state_ff)
         S_CUT: begin
            mul_req.start = 1'b1;
            mul_req.a = MUL_W'(one_minus_a);
            mul_req.b = MUL_W'(nearest_ff);
         end
         S_JRD: begin
            mul_req.start = (pr_rd_ff != '0);
            mul_req.a = MUL_W'(ssf_ff);
            mul_req.b = MUL_W'(pr_rd_ff);
         end
         S_DEN: begin
            div_req.start = (mag_ff < mul_p[47:0]);
            div_req.rem   = DIV_W'(mag_ff);
            div_req.den   = DIV_W'(mul_p[47:0]);
            div_req.steps = STEP_W'(FRAC_W);
         end
         S_T1: begin
            mul_req.start = 1'b1;
            mul_req.a = MUL_W'(div_q[FRAC_W-1:0]);
            mul_req.b = MUL_W'(div_q[FRAC_W-1:0]);
         end
         S_T2: begin
            mul_req.start = 1'b1;
            mul_req.a = MUL_W'(t_ff);
            mul_req.b = MUL_W'(hi31);
         end
         S_T3, S_T5: begin
            mul_req.start = 1'b1;
            mul_req.a = MUL_W'(hi31);
            mul_req.b = MUL_W'(t2_ff);
         end
         S_PSM: begin
            mul_req.start = 1'b1;
            mul_req.a = MUL_W'(ps_ff);
            mul_req.b = MUL_W'(s_ff);
         end
         S_FIN: begin
            mul_req.start = 1'b1;
            mul_req.a = w_ff;
            mul_req.b = MUL_W'(pp_ff);
         end
         S_FDIV: begin
            div_req.start = 1'b1;
            div_req.num   = mul_p;
            div_req.den   = sum_ff;
            div_req.steps = STEP_W'(DIVN_W);
         end
         default: ;
      endcase
   end

   ssfpw_mul_unit u_mul (
      .clock(clock), .reset(reset), .req(mul_req), .sts(mul_sts), .product(mul_p)
   );

   ssfpw_div_unit u_div (
      .clock(clock), .reset(reset), .req(div_req), .sts(div_sts), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (accept && req_ch.opcode == OP_LOAD_POINT && 32'(req_ch.atom_row) < MAX_ATOMS)
         point_mem[AW'(req_ch.atom_row)] <= req_ch.distance_value;
      pt_rd_ff <= point_mem[pt_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.opcode == OP_LOAD_PAIR && 32'(req_ch.atom_row) < MAX_ATOMS
          && 32'(req_ch.atom_col) < MAX_ATOMS)
         pair_mem[{AW'(req_ch.atom_row), AW'(req_ch.atom_col)}] <= req_ch.distance_value;
      pr_rd_ff <= pair_mem[{cell_ff[AW-1:0], j_ff[AW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         atom_count_ff <= ATOM_COUNT_RST;
         ssf_ff        <= SSF_FACTOR_RST;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_ATOM_COUNT: atom_count_ff <= csr_write_data[6:0];
               REG_SSF_FACTOR: ssf_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && req_ch.opcode == OP_COMPUTE) begin
                  parent_ff  <= req_ch.parent_atom;
                  nearest_ff <= req_ch.nearest_distance;
                  w_ff       <= req_ch.weight_in;
                  state_ff   <= S_CHK;
               end
            end
            S_CHK: begin
               if (32'(parent_ff) >= 32'(n_atoms)) begin
                  res_w_ff  <= '0;
                  res_st_ff <= ST_ZEROED;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_CUT;
               end
            end
            S_CUT: begin
               ri_ff    <= pt_rd_ff;
               ret_ff   <= S_CUTD;
               state_ff <= S_MW;
            end
            S_CUTD: begin
               if ({ri_ff, 17'b0} < mul_p[48:0]) begin
                  res_w_ff  <= w_ff;
                  res_st_ff <= ST_SKIPPED;
                  state_ff  <= S_OUT;
               end else begin
                  cell_ff  <= CW'(par_idx);
                  first_ff <= 1'b1;
                  state_ff <= S_CELL;
               end
            end
            S_CELL: begin
               ps_ff    <= Q46_ONE;
               j_ff     <= '0;
               state_ff <= S_CELLR;
            end
            S_CELLR: begin
               ri_ff    <= pt_rd_ff;
               state_ff <= S_JCHK;
            end
            S_JCHK: begin
               if (j_ff == n_atoms || ps_ff <= TOL_Q46)
                  state_ff <= S_CEND;
               else if (j_ff == cell_ff)
                  j_ff <= j_ff + CW'(1);
               else
                  state_ff <= S_JRD;
            end
            S_JRD: begin
               pos_ff <= ri_ge;
               mag_ff <= {dabs, 16'b0};
               if (pr_rd_ff == '0) begin
                  s_ff     <= (ri_ff > pt_rd_ff) ? '0 : Q46_ONE;
                  state_ff <= S_PSM;
               end else begin
                  ret_ff   <= S_DEN;
                  state_ff <= S_MW;
               end
            end
            S_DEN: begin
               if (mag_ff >= mul_p[47:0]) begin
                  s_ff     <= pos_ff ? '0 : Q46_ONE;
                  state_ff <= S_PSM;
               end else begin
                  ret_ff   <= S_T1;
                  state_ff <= S_DW;
               end
            end
            S_T1: begin
               t_ff     <= div_q[FRAC_W-1:0];
               ret_ff   <= S_T2;
               state_ff <= S_MW;
            end
            S_T2: begin
               t2_ff    <= hi31;
               ret_ff   <= S_T3;
               state_ff <= S_MW;
            end
            S_T3: begin
               t3_ff    <= hi31;
               ret_ff   <= S_T5;
               state_ff <= S_MW;
            end
            S_T5: begin
               t5_ff    <= hi31;
               ret_ff   <= S_T7;
               state_ff <= S_MW;
            end
            S_T7: begin
               s_ff     <= pos_ff ? {1'b0, s_minus[PROD_W-1:1]} : s_plus[PROD_W:1];
               state_ff <= S_PSM;
            end
            S_PSM: begin
               ret_ff   <= S_PSD;
               state_ff <= S_MW;
            end
            S_PSD: begin
               ps_ff    <= mul_p[46+PROD_W-1:46];
               j_ff     <= j_ff + CW'(1);
               state_ff <= S_JCHK;
            end
            S_CEND: begin
               if (first_ff) begin
                  if (ps_ff == '0) begin
                     res_w_ff  <= '0;
                     res_st_ff <= ST_ZEROED;
                     state_ff  <= S_OUT;
                  end else begin
                     pp_ff    <= ps_ff;
                     sum_ff   <= SUM_W'(ps_ff);
                     first_ff <= 1'b0;
                     cell_ff  <= '0;
                     state_ff <= S_CNEXT;
                  end
               end else begin
                  sum_ff   <= sum_ff + SUM_W'(ps_ff);
                  cell_ff  <= cell_ff + CW'(1);
                  state_ff <= S_CNEXT;
               end
            end
            S_CNEXT: begin
               if (cell_ff == n_atoms)
                  state_ff <= S_FIN;
               else if (cell_ff == CW'(par_idx))
                  cell_ff <= cell_ff + CW'(1);
               else
                  state_ff <= S_CELL;
            end
            S_FIN: begin
               ret_ff   <= S_FDIV;
               state_ff <= S_MW;
            end
            S_FDIV: begin
               ret_ff   <= S_FQ;
               state_ff <= S_DW;
            end
            S_FQ: begin
               res_w_ff  <= div_q;
               res_st_ff <= ST_SCALED;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_w_ff     <= res_w_ff;
                  rsp_st_ff    <= res_st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_MW: if (mul_sts.done) state_ff <= ret_ff;
            S_DW: if (div_sts.done) state_ff <= ret_ff;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.weight_out = rsp_w_ff;
   assign rsp_ch.status     = rsp_st_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.busy && div_sts.busy))
      else $error("multiplier and divider busy together");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.status == ST_SCALED || rsp_ch.status == ST_SKIPPED
                        || rsp_ch.status == ST_ZEROED))
      else $error("illegal status code");

   a_zeroed_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_ZEROED) |-> (rsp_ch.weight_out == '0))
      else $error("zeroed item with nonzero weight");

   a_wait_has_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MW) |-> (mul_sts.busy || mul_sts.done))
      else $error("waiting on idle multiplier");
endmodule
`default_nettype wire

[test/ssf_partition_weight_core_test.sv]
// Self-checking testbench for ssf_partition_weight_core: loads, cutoff skips, zeroed items and weight scaling.
`default_nettype none
module ssf_partition_weight_core_test;
   import ssfpw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int IDLE_LIMIT = 2000000;

   typedef struct {
      logic [1:0]  opcode;
      logic [5:0]  atom_row;
      logic [5:0]  atom_col;
      logic [31:0] distance_value;
      logic [5:0]  parent_atom;
      logic [31:0] nearest_distance;
      logic [47:0] weight_in;
   } point_item_type;

   typedef struct {
      logic [47:0] weight;
      logic [1:0]  status;
   } weight_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   ssfpw_req_if req_bus();
   ssfpw_rsp_if rsp_bus();

   ssf_partition_weight_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's stores and registers
   logic [31:0] pair_shadow [0:4095];
   logic [31:0] point_shadow [0:63];
   logic [6:0]  atom_count_shadow = ATOM_COUNT_RST;
   logic [15:0] ssf_factor_shadow = SSF_FACTOR_RST;

   point_item_type    pending_items [$];
   weight_result_type expected_weights [$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic logic [46:0] switch_value(logic [31:0] ri, logic [31:0] rj,
                                                logic [31:0] rab);
      logic pos;
      longint unsigned mag, den, g;
      longint t, t2, t3, t5, t7, num;
      logic [127:0] wide;
      pos = ri >= rj;
      if (rab == 0) return (ri > rj) ? 47'd0 : Q46_ONE;
      mag = pos ? 64'(ri - rj) : 64'(rj - ri);
      mag = mag << 16;
      den = 64'(ssf_factor_shadow) * 64'(rab);
      if (mag >= den) return pos ? 47'd0 : Q46_ONE;
      wide = (128'(mag) << 31) / 128'(den);
      t  = longint'(wide[63:0]);
      t2 = (t * t) >>> 31;
      t3 = (t * t2) >>> 31;
      t5 = (t3 * t2) >>> 31;
      t7 = (t5 * t2) >>> 31;
      num = 35 * (t - t3) + 21 * t5 - 5 * t7;
      if (num < 0) num = 0;
      g = longint'(num) << 11;
      if (g > 64'(Q46_ONE)) g = 64'(Q46_ONE);
      return pos ? 47'((64'(Q46_ONE) - g) >> 1) : 47'((64'(Q46_ONE) + g) >> 1);
   endfunction

   function automatic longint unsigned cell_weight(int i, int n);
      longint unsigned ps;
      logic [127:0] prod;
      ps = 64'(Q46_ONE);
      for (int j = 0; j < n; j++) begin
         if (ps <= 64'(TOL_Q46)) break;
         if (j == i) continue;
         prod = 128'(ps) * 128'(switch_value(point_shadow[i], point_shadow[j],
                                             pair_shadow[i*64+j]));
         ps = 64'(prod >> 46);
      end
      return ps;
   endfunction

   function automatic weight_result_type scale_weight(point_item_type it);
      weight_result_type r;
      int n;
      longint unsigned pp, sum;
      logic [127:0] q;
      n = (atom_count_shadow > 64) ? 64 : int'(atom_count_shadow);
      if (int'(it.parent_atom) >= n) begin
         r.weight = '0; r.status = ST_ZEROED;
         return r;
      end
      if ((64'(point_shadow[it.parent_atom]) << 17) <
          64'(17'd65536 - 17'(ssf_factor_shadow)) * 64'(it.nearest_distance)) begin
         r.weight = it.weight_in; r.status = ST_SKIPPED;
         return r;
      end
      pp = cell_weight(it.parent_atom, n);
      if (pp == 0) begin
         r.weight = '0; r.status = ST_ZEROED;
         return r;
      end
      sum = pp;
      for (int i = 0; i < n; i++)
         if (i != it.parent_atom) sum += cell_weight(i, n);
      q = (128'(it.weight_in) * 128'(pp)) / 128'(sum);
      r.weight = q[47:0];
      r.status = ST_SCALED;
      return r;
   endfunction

   function automatic void apply_item(point_item_type it);
      case (it.opcode)
         OP_LOAD_PAIR: begin
            pair_shadow[it.atom_row*64 + it.atom_col] = it.distance_value;
         end
         OP_LOAD_POINT: begin
            point_shadow[it.atom_row] = it.distance_value;
         end
         OP_COMPUTE: begin
            expected_weights.push_back(scale_weight(it));
         end
         default: ;
      endcase
   endfunction

   // driver: bursts of items separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            apply_item(pending_items[0]);
            void'(pending_items.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_bus.valid            <= 1'b1;
            req_bus.opcode           <= pending_items[0].opcode;
            req_bus.atom_row         <= pending_items[0].atom_row;
            req_bus.atom_col         <= pending_items[0].atom_col;
            req_bus.distance_value   <= pending_items[0].distance_value;
            req_bus.parent_atom      <= pending_items[0].parent_atom;
            req_bus.nearest_distance <= pending_items[0].nearest_distance;
            req_bus.weight_in        <= pending_items[0].weight_in;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: checks results and stalls the receiver in randomly chosen modes
   int stall_mode = 0;
   int stall_tick = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_weights.size() == 0) begin
               $display("%0t: result with none expected: weight %h status %0d",
                        $time, rsp_bus.weight_out, rsp_bus.status);
               errors++;
            end else begin
               if (rsp_bus.weight_out !== expected_weights[0].weight ||
                   rsp_bus.status !== expected_weights[0].status) begin
                  $display("%0t: mismatch: expected weight %h status %0d, got weight %h status %0d",
                           $time, expected_weights[0].weight, expected_weights[0].status,
                           rsp_bus.weight_out, rsp_bus.status);
                  errors++;
               end
               void'(expected_weights.pop_front());
            end
         end
         stall_tick++;
         if (stall_tick == 64) begin
            stall_tick = 0;
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= $urandom_range(0, 1);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("ssf_partition_weight_core_test: FAIL");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] op, int row, int col, logic [31:0] dist_value,
                            int parent, logic [31:0] nearest, logic [47:0] w);
      point_item_type it;
      it.opcode = op;
      it.atom_row = 6'(row);
      it.atom_col = 6'(col);
      it.distance_value = dist_value;
      it.parent_atom = 6'(parent);
      it.nearest_distance = nearest;
      it.weight_in = w;
      pending_items.push_back(it);
   endtask

   task automatic settle();
      while (pending_items.size() > 0 || req_bus.valid || expected_weights.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_ATOM_COUNT) atom_count_shadow = value[6:0];
      else ssf_factor_shadow = value;
   endtask

   function automatic logic [47:0] random_weight();
      return {$urandom, $urandom} & {48{1'b1}};
   endfunction

   function automatic logic [31:0] random_distance();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         default: return $urandom_range(0, 32'h0010_0000);
      endcase
   endfunction

   task automatic load_atoms(int n);
      for (int i = 0; i < n; i++) begin
         push_item(OP_LOAD_POINT, i, $urandom_range(0, 63), random_distance(),
                   $urandom_range(0, 63), $urandom, random_weight());
         for (int j = 0; j < n; j++)
            push_item(OP_LOAD_PAIR, i, j, random_distance(),
                      $urandom_range(0, 63), $urandom, random_weight());
      end
   endtask

   task automatic random_phase(int n, int count);
      int kind, p;
      load_atoms(n);
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 19);
         p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
         if (kind < 13)
            push_item(OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, p,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096),
                      random_weight());
         else if (kind < 16)
            push_item(OP_LOAD_POINT, $urandom_range(0, 63), $urandom_range(0, 63),
                      random_distance(), p, $urandom, random_weight());
         else if (kind < 19)
            push_item(OP_LOAD_PAIR, $urandom_range(0, 63), $urandom_range(0, 63),
                      random_distance(), p, $urandom, random_weight());
         else
            push_item(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                      $urandom_range(0, 63), $urandom, random_weight());
      end
      settle();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_NOP;
      req_bus.atom_row = '0;
      req_bus.atom_col = '0;
      req_bus.distance_value = '0;
      req_bus.parent_atom = '0;
      req_bus.nearest_distance = '0;
      req_bus.weight_in = '0;
      rsp_bus.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single atom at reset settings
      push_item(OP_LOAD_POINT, 0, 0, 32'h0000_8000, 0, 0, 0);
      push_item(OP_LOAD_PAIR, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      push_item(OP_COMPUTE, 0, 0, 0, 0, 32'd0, {48{1'b1}});
      push_item(OP_COMPUTE, 63, 63, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, {48{1'b1}});
      push_item(OP_COMPUTE, 0, 0, 0, 0, 32'd0, 48'd0);
      push_item(OP_COMPUTE, 0, 0, 0, 63, 32'd5, 48'h1234_5678_9ABC);
      push_item(OP_NOP, 63, 63, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, {48{1'b1}});
      settle();

      // three atoms, extreme a = 1.0-, zero pair distances and equal distances
      write_csr(REG_ATOM_COUNT, 16'd3);
      write_csr(REG_SSF_FACTOR, 16'd65535);
      push_item(OP_LOAD_POINT, 0, 0, 32'h0001_0000, 0, 0, 0);
      push_item(OP_LOAD_POINT, 1, 0, 32'h0001_0000, 0, 0, 0);
      push_item(OP_LOAD_POINT, 2, 0, 32'h0001_8000, 0, 0, 0);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            push_item(OP_LOAD_PAIR, i, j, (i + j == 3) ? 32'd0 : 32'h0002_0000, 0, 0, 0);
      push_item(OP_COMPUTE, 0, 0, 0, 0, 32'd0, 48'h0001_0000_0000);
      push_item(OP_COMPUTE, 0, 0, 0, 1, 32'd0, {48{1'b1}});
      push_item(OP_COMPUTE, 0, 0, 0, 2, 32'd0, 48'h8000_0000_0001);
      push_item(OP_COMPUTE, 0, 0, 0, 3, 32'd0, 48'h1);
      settle();
      random_phase(3, 12);

      write_csr(REG_ATOM_COUNT, 16'd2);
      write_csr(REG_SSF_FACTOR, 16'd1);
      random_phase(2, 10);

      write_csr(REG_ATOM_COUNT, 16'd4);
      write_csr(REG_SSF_FACTOR, 16'd41943);
      random_phase(4, 12);

      write_csr(REG_ATOM_COUNT, 16'd2);
      write_csr(REG_SSF_FACTOR, 16'($urandom_range(1, 65535)));
      random_phase(2, 10);

      write_csr(REG_ATOM_COUNT, 16'd3);
      write_csr(REG_SSF_FACTOR, 16'($urandom_range(20000, 60000)));
      random_phase(3, 10);

      // atom count above the limit acts as the limit; points skipped by cutoff
      write_csr(REG_ATOM_COUNT, 16'd127);
      push_item(OP_LOAD_POINT, 40, 0, 32'h0000_0010, 0, 0, 0);
      push_item(OP_LOAD_POINT, 63, 0, 32'h0000_0001, 0, 0, 0);
      push_item(OP_COMPUTE, 0, 0, 0, 40, 32'hFFFF_FFFF, random_weight());
      push_item(OP_COMPUTE, 0, 0, 0, 63, 32'h0001_0000, random_weight());
      settle();
      repeat (200) @(posedge clock);

      if (errors == 0)
         $display("ssf_partition_weight_core_test: PASS");
      else
         $display("ssf_partition_weight_core_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
